// File: rtl/core/gwp_pkg.sv
// Shared types, character codes and field decode for the G-code word parser.
`default_nettype none
package gwp_pkg;

	localparam int MAX_DIGITS_DEF = 8;
	localparam int AXES_DEF       = 3;
	localparam int FIFO_DEPTH     = 4;

	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;

	localparam logic [4:0] LT_A = 5'd0;
	localparam logic [4:0] LT_B = 5'd1;
	localparam logic [4:0] LT_F = 5'd5;
	localparam logic [4:0] LT_G = 5'd6;
	localparam logic [4:0] LT_I = 5'd8;
	localparam logic [4:0] LT_J = 5'd9;
	localparam logic [4:0] LT_K = 5'd10;
	localparam logic [4:0] LT_R = 5'd17;
	localparam logic [4:0] LT_V = 5'd21;
	localparam logic [4:0] LT_W = 5'd22;
	localparam logic [4:0] LT_X = 5'd23;
	localparam logic [4:0] LT_Y = 5'd24;
	localparam logic [4:0] LT_Z = 5'd25;

	localparam logic [3:0] TGT_NONE   = 4'd0;
	localparam logic [3:0] TGT_MOTION = 4'd1;
	localparam logic [3:0] TGT_FEED   = 4'd2;
	localparam logic [3:0] TGT_I      = 4'd3;
	localparam logic [3:0] TGT_J      = 4'd4;
	localparam logic [3:0] TGT_K      = 4'd5;
	localparam logic [3:0] TGT_RADIUS = 4'd6;
	localparam logic [3:0] TGT_TLEN   = 4'd7;
	localparam logic [3:0] TGT_TDIA   = 4'd8;
	localparam logic [3:0] TGT_X      = 4'd9;
	localparam logic [3:0] TGT_Y      = 4'd10;
	localparam logic [3:0] TGT_Z      = 4'd11;
	localparam logic [3:0] TGT_A      = 4'd12;
	localparam logic [3:0] TGT_B      = 4'd13;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_LETTER_EXP = 2'd1;
	localparam logic [1:0] ST_VALUE_EXP  = 2'd2;
	localparam logic [1:0] ST_OVER_255   = 2'd3;

	localparam logic signed [7:0] EXP_MAX = 8'sd127;
	localparam logic [8:0] IP_SAT  = 9'd256;
	localparam logic [8:0] IP_LIM  = 9'd255;
	localparam logic [8:0] IP_GMAX = 9'd3;

	typedef enum logic [1:0] {
		PH_LETTER,
		PH_AFTER,
		PH_NUMBER,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       line_end;
	} req_t;

	typedef struct packed {
		logic [4:0]        letter;
		logic              negative;
		logic [26:0]       mantissa;
		logic signed [7:0] exponent;
		logic [3:0]        target;
		logic [1:0]        status;
		logic              last;
	} rsp_t;

	function automatic logic [3:0] target_of(input logic [4:0] ltr, input logic neg,
			input logic [8:0] ip, input int axes);
		logic [3:0] t;
		unique case (ltr)
			LT_G: t = (!neg && ip <= IP_GMAX) ? TGT_MOTION : TGT_NONE;
			LT_F: t = TGT_FEED;
			LT_I: t = TGT_I;
			LT_J: t = TGT_J;
			LT_K: t = TGT_K;
			LT_R: t = TGT_RADIUS;
			LT_V: t = TGT_TLEN;
			LT_W: t = TGT_TDIA;
			LT_X: t = TGT_X;
			LT_Y: t = TGT_Y;
			LT_Z: t = TGT_Z;
			LT_A: t = (axes > 3) ? TGT_A : TGT_NONE;
			LT_B: t = (axes > 4) ? TGT_B : TGT_NONE;
			default: t = TGT_NONE;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/gcode_word_parser.sv
// Top level of the G-code word parser: character decode, word state and result queue.
//
// Usage: the req channel carries one line character per transfer (ch, line_end);
// the rsp channel returns one parsed G-code word or error per word. Both are
// valid/ready channels. A character is decoded by a single pass of logic into
// the word state registers; each character yields zero, one or two results,
// which are written into a four-entry result queue.
// Results are registered in the queue and presented on rsp from its head.
// Throughput is one character per cycle while the queue has room for two
// results; req_ready drops when fewer than two entries are free, so a stalled
// receiver backs up into the sender after at most four results. Results leave
// at one per cycle while rsp_ready is high; a character that ends a word yields
// two results only when it also raises an error.
// Reset clears the word state to "expect letter" and empties the queue.
// After an error the rest of the line is skipped without results.
`default_nettype none
module gcode_word_parser #(
	parameter int MAX_DIGITS = gwp_pkg::MAX_DIGITS_DEF,
	parameter int AXES       = gwp_pkg::AXES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire gwp_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output gwp_pkg::rsp_t      rsp
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 2);
	localparam int PTR_W = $clog2(gwp_pkg::FIFO_DEPTH);
	localparam int FCNT_W = $clog2(gwp_pkg::FIFO_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

	gwp_pkg::phase_t   phase_q, nx_phase;
	logic [4:0]        letter_q, nx_letter;
	logic              sign_q, nx_sign;
	logic [26:0]       val_q, nx_val, dg_val;
	logic signed [7:0] exp_q, nx_exp, dg_exp;
	logic [CNT_W-1:0]  cnt_q, nx_cnt, dg_cnt;
	logic              point_q, nx_point;
	logic [8:0]        ip_q, nx_ip, dg_ip;
	logic              fnz_q, nx_fnz, dg_fnz;

	gwp_pkg::rsp_t     mem_q [gwp_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]  wptr_q, rptr_q;
	logic [FCNT_W-1:0] fcnt_q;

	gwp_pkg::rsp_t res0, res1, word_r, tl_r;
	logic [1:0]    n_res;
	logic          take, close, accept, pop;
	logic          is_digit, is_letter, is_dot, is_sign;
	logic [3:0]    d;
	logic          keep;
	logic [11:0]   ip_ext, ip_prod;
	logic [4:0]    ch_letter;

	assign accept = req_valid && req_ready;
	assign pop    = rsp_valid && rsp_ready;

	assign is_digit  = req.ch >= gwp_pkg::CH_0 && req.ch <= gwp_pkg::CH_9;
	assign is_letter = req.ch >= gwp_pkg::CH_A && req.ch <= gwp_pkg::CH_Z;
	assign is_dot    = req.ch == gwp_pkg::CH_DOT;
	assign is_sign   = req.ch == gwp_pkg::CH_MINUS || req.ch == gwp_pkg::CH_PLUS;
	assign d         = 4'(req.ch - gwp_pkg::CH_0);
	assign ch_letter = 5'(req.ch - gwp_pkg::CH_A);

	// digit accumulation from the current word state
	always_comb begin
		dg_cnt = (cnt_q <= CNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;
		keep   = dg_cnt <= CNT_MAX;
		dg_val = val_q;
		dg_exp = exp_q;
		dg_fnz = fnz_q;
		if (keep) begin
			dg_val = 27'({val_q, 3'b000} + {val_q, 1'b0} + {23'd0, d});
			if (point_q) begin
				dg_exp = exp_q - 8'sd1;
				dg_fnz = fnz_q || (d != 4'd0);
			end
		end else if (!point_q && exp_q < gwp_pkg::EXP_MAX) begin
			dg_exp = exp_q + 8'sd1;
		end
		ip_ext  = {3'b000, ip_q};
		ip_prod = {ip_ext[8:0], 3'b000} + {ip_ext[10:0], 1'b0} + {8'd0, d};
		dg_ip   = ip_q;
		if (!point_q) begin
			dg_ip = (ip_prod > 12'(gwp_pkg::IP_SAT)) ? gwp_pkg::IP_SAT : ip_prod[8:0];
		end
	end

	always_comb begin
		nx_phase  = phase_q;
		nx_letter = letter_q;
		nx_sign   = sign_q;
		nx_val    = val_q;
		nx_exp    = exp_q;
		nx_cnt    = cnt_q;
		nx_point  = point_q;
		nx_ip     = ip_q;
		nx_fnz    = fnz_q;
		res0      = '0;
		res1      = '0;
		n_res     = 2'd0;
		take      = 1'b0;
		close     = 1'b0;
		word_r    = '0;
		tl_r      = '0;
		unique case (phase_q)
			gwp_pkg::PH_SKIP: begin
				if (req.line_end) nx_phase = gwp_pkg::PH_LETTER;
			end
			gwp_pkg::PH_LETTER: begin
				take = 1'b1;
			end
			default: begin
				if (is_digit) begin
					nx_val   = dg_val;
					nx_exp   = dg_exp;
					nx_cnt   = dg_cnt;
					nx_ip    = dg_ip;
					nx_fnz   = dg_fnz;
					nx_phase = gwp_pkg::PH_NUMBER;
					close    = req.line_end;
				end else if (is_dot && !point_q) begin
					nx_point = 1'b1;
					nx_phase = gwp_pkg::PH_NUMBER;
					close    = req.line_end;
				end else if (phase_q == gwp_pkg::PH_AFTER && is_sign) begin
					nx_sign  = req.ch == gwp_pkg::CH_MINUS;
					nx_phase = gwp_pkg::PH_NUMBER;
					close    = req.line_end;
				end else if (cnt_q == '0) begin
					res0.letter = letter_q;
					res0.status = gwp_pkg::ST_VALUE_EXP;
					res0.last   = req.line_end;
					n_res       = 2'd1;
					nx_phase    = req.line_end ? gwp_pkg::PH_LETTER : gwp_pkg::PH_SKIP;
				end else begin
					n_res = 2'd1;
					take  = 1'b1;
				end
			end
		endcase

		// word as it stands after this character's update
		word_r.letter   = nx_letter;
		word_r.negative = nx_sign;
		word_r.mantissa = nx_val;
		word_r.exponent = nx_exp;
		word_r.target   = gwp_pkg::target_of(nx_letter, nx_sign, nx_ip, AXES);
		word_r.status   = gwp_pkg::ST_OK;
		if ((nx_letter == gwp_pkg::LT_V || nx_letter == gwp_pkg::LT_W) && !nx_sign &&
				(nx_ip > gwp_pkg::IP_LIM || (nx_ip == gwp_pkg::IP_LIM && nx_fnz))) begin
			word_r.status = gwp_pkg::ST_OVER_255;
		end

		if (close) begin
			nx_phase = gwp_pkg::PH_LETTER;
			n_res    = 2'd1;
			if (nx_cnt != '0) begin
				res0      = word_r;
				res0.last = 1'b1;
			end else begin
				res0.letter = nx_letter;
				res0.status = gwp_pkg::ST_VALUE_EXP;
				res0.last   = 1'b1;
			end
		end else if (take) begin
			if (n_res == 2'd1) res0 = word_r;
			if (is_letter) begin
				tl_r.letter = ch_letter;
				tl_r.status = gwp_pkg::ST_VALUE_EXP;
				tl_r.last   = 1'b1;
				nx_letter   = ch_letter;
				nx_sign     = 1'b0;
				nx_val      = '0;
				nx_exp      = '0;
				nx_cnt      = '0;
				nx_point    = 1'b0;
				nx_ip       = '0;
				nx_fnz      = 1'b0;
				nx_phase    = req.line_end ? gwp_pkg::PH_LETTER : gwp_pkg::PH_AFTER;
			end else begin
				tl_r.status = gwp_pkg::ST_LETTER_EXP;
				tl_r.last   = req.line_end;
				nx_phase    = req.line_end ? gwp_pkg::PH_LETTER : gwp_pkg::PH_SKIP;
			end
			if (!is_letter || req.line_end) begin
				if (n_res == 2'd1) begin
					res1 = tl_r;
				end else begin
					res0 = tl_r;
				end
				n_res = n_res + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= gwp_pkg::PH_LETTER;
			letter_q <= '0;
			sign_q   <= 1'b0;
			val_q    <= '0;
			exp_q    <= '0;
			cnt_q    <= '0;
			point_q  <= 1'b0;
			ip_q     <= '0;
			fnz_q    <= 1'b0;
		end else if (accept) begin
			phase_q  <= nx_phase;
			letter_q <= nx_letter;
			sign_q   <= nx_sign;
			val_q    <= nx_val;
			exp_q    <= nx_exp;
			cnt_q    <= nx_cnt;
			point_q  <= nx_point;
			ip_q     <= nx_ip;
			fnz_q    <= nx_fnz;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && n_res != 2'd0) begin
			mem_q[wptr_q] <= res0;
			if (n_res == 2'd2) mem_q[wptr_q + PTR_W'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fcnt_q <= '0;
		end else begin
			if (accept) wptr_q <= wptr_q + PTR_W'(n_res);
			if (pop) rptr_q <= rptr_q + PTR_W'(1);
			fcnt_q <= fcnt_q + (accept ? FCNT_W'(n_res) : FCNT_W'(0)) - FCNT_W'(pop);
		end
	end

	assign req_ready = fcnt_q <= FCNT_W'(gwp_pkg::FIFO_DEPTH - 2);
	assign rsp_valid = fcnt_q != '0;
	assign rsp       = mem_q[rptr_q];

endmodule
`default_nettype wire

// File: tb/sv/gcode_word_parser_test.sv
// Self-checking testbench for gcode_word_parser: character stream in, parsed words checked.
module gcode_word_parser_test;

	localparam int CYCLE_LIMIT = 400000;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	gwp_pkg::req_t  req = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	gwp_pkg::rsp_t  rsp;

	gcode_word_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	gwp_pkg::req_t chars_pending[$];
	gwp_pkg::rsp_t words_due[$];
	byte unsigned  line_text[$];

	int mismatches = 0;
	int accepted_chars = 0;
	int cycles = 0;

	gwp_pkg::phase_t ph = gwp_pkg::PH_LETTER;
	logic [4:0]  w_letter = '0;
	logic        w_neg = 1'b0;
	logic [26:0] w_mant = '0;
	int          w_exp = 0;
	int          w_count = 0;
	logic        w_point = 1'b0;
	int          w_int = 0;
	logic        w_frac_nz = 1'b0;

	function automatic logic [3:0] field_code(input logic [4:0] ltr, input logic neg,
			input int ip);
		logic [3:0] t;
		case (ltr)
			gwp_pkg::LT_G: t = (!neg && ip <= 3) ? gwp_pkg::TGT_MOTION : gwp_pkg::TGT_NONE;
			gwp_pkg::LT_F: t = gwp_pkg::TGT_FEED;
			gwp_pkg::LT_I: t = gwp_pkg::TGT_I;
			gwp_pkg::LT_J: t = gwp_pkg::TGT_J;
			gwp_pkg::LT_K: t = gwp_pkg::TGT_K;
			gwp_pkg::LT_R: t = gwp_pkg::TGT_RADIUS;
			gwp_pkg::LT_V: t = gwp_pkg::TGT_TLEN;
			gwp_pkg::LT_W: t = gwp_pkg::TGT_TDIA;
			gwp_pkg::LT_X: t = gwp_pkg::TGT_X;
			gwp_pkg::LT_Y: t = gwp_pkg::TGT_Y;
			gwp_pkg::LT_Z: t = gwp_pkg::TGT_Z;
			gwp_pkg::LT_A: t = (gwp_pkg::AXES_DEF > 3) ? gwp_pkg::TGT_A : gwp_pkg::TGT_NONE;
			gwp_pkg::LT_B: t = (gwp_pkg::AXES_DEF > 4) ? gwp_pkg::TGT_B : gwp_pkg::TGT_NONE;
			default: t = gwp_pkg::TGT_NONE;
		endcase
		return t;
	endfunction

	function automatic gwp_pkg::rsp_t fault(input logic [4:0] ltr, input logic [1:0] st,
			input logic fin);
		gwp_pkg::rsp_t r;
		r = '0;
		r.letter = ltr;
		r.status = st;
		r.last = fin;
		return r;
	endfunction

	function automatic gwp_pkg::rsp_t word_result(input logic fin);
		gwp_pkg::rsp_t r;
		r.letter = w_letter;
		r.negative = w_neg;
		r.mantissa = w_mant;
		r.exponent = w_exp[7:0];
		r.target = field_code(w_letter, w_neg, w_int);
		r.status = gwp_pkg::ST_OK;
		if ((w_letter == gwp_pkg::LT_V || w_letter == gwp_pkg::LT_W) && !w_neg &&
				(w_int > 255 || (w_int == 255 && w_frac_nz)))
			r.status = gwp_pkg::ST_OVER_255;
		r.last = fin;
		return r;
	endfunction

	task automatic open_word(input logic [7:0] c, input logic fin);
		logic [7:0] idx;
		if (c >= gwp_pkg::CH_A && c <= gwp_pkg::CH_Z) begin
			idx = c - gwp_pkg::CH_A;
			w_letter = idx[4:0];
			w_neg = 1'b0;
			w_mant = '0;
			w_exp = 0;
			w_count = 0;
			w_point = 1'b0;
			w_int = 0;
			w_frac_nz = 1'b0;
			if (fin) begin
				words_due.push_back(fault(w_letter, gwp_pkg::ST_VALUE_EXP, 1'b1));
				ph = gwp_pkg::PH_LETTER;
			end else begin
				ph = gwp_pkg::PH_AFTER;
			end
		end else begin
			words_due.push_back(fault(5'd0, gwp_pkg::ST_LETTER_EXP, fin));
			ph = fin ? gwp_pkg::PH_LETTER : gwp_pkg::PH_SKIP;
		end
	endtask

	task automatic take_digit(input int d);
		if (w_count <= gwp_pkg::MAX_DIGITS_DEF)
			w_count++;
		if (w_count <= gwp_pkg::MAX_DIGITS_DEF) begin
			if (w_point) begin
				w_exp--;
				if (d != 0)
					w_frac_nz = 1'b1;
			end
			w_mant = 27'(w_mant * 10 + d);
		end else if (!w_point && w_exp < int'(gwp_pkg::EXP_MAX)) begin
			w_exp++;
		end
		if (!w_point) begin
			w_int = w_int * 10 + d;
			if (w_int > int'(gwp_pkg::IP_SAT))
				w_int = int'(gwp_pkg::IP_SAT);
		end
	endtask

	task automatic close_line();
		ph = gwp_pkg::PH_LETTER;
		if (w_count > 0)
			words_due.push_back(word_result(1'b1));
		else
			words_due.push_back(fault(w_letter, gwp_pkg::ST_VALUE_EXP, 1'b1));
	endtask

	task automatic parse_char(input gwp_pkg::req_t item);
		logic [7:0] c;
		logic       fin;
		c = item.ch;
		fin = item.line_end;
		case (ph)
			gwp_pkg::PH_SKIP: begin
				if (fin)
					ph = gwp_pkg::PH_LETTER;
			end
			gwp_pkg::PH_LETTER: open_word(c, fin);
			default: begin
				if (c >= gwp_pkg::CH_0 && c <= gwp_pkg::CH_9) begin
					take_digit(int'(c - gwp_pkg::CH_0));
					ph = gwp_pkg::PH_NUMBER;
					if (fin)
						close_line();
				end else if (c == gwp_pkg::CH_DOT && !w_point) begin
					w_point = 1'b1;
					ph = gwp_pkg::PH_NUMBER;
					if (fin)
						close_line();
				end else if (ph == gwp_pkg::PH_AFTER &&
						(c == gwp_pkg::CH_MINUS || c == gwp_pkg::CH_PLUS)) begin
					w_neg = (c == gwp_pkg::CH_MINUS);
					ph = gwp_pkg::PH_NUMBER;
					if (fin)
						close_line();
				end else if (w_count == 0) begin
					words_due.push_back(fault(w_letter, gwp_pkg::ST_VALUE_EXP, fin));
					ph = fin ? gwp_pkg::PH_LETTER : gwp_pkg::PH_SKIP;
				end else begin
					words_due.push_back(word_result(1'b0));
					open_word(c, fin);
				end
			end
		endcase
	endtask

	task automatic flag(input string what, input int want, input int got);
		$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		mismatches++;
	endtask

	task automatic check_word(input gwp_pkg::rsp_t got);
		gwp_pkg::rsp_t want;
		if (words_due.size() == 0) begin
			$display("%0t: no word expected, got letter %0d status %0d last %0d",
				$time, got.letter, got.status, got.last);
			mismatches++;
		end else begin
			want = words_due.pop_front();
			if (got.letter !== want.letter)
				flag("letter", int'(want.letter), int'(got.letter));
			if (got.negative !== want.negative)
				flag("negative", int'(want.negative), int'(got.negative));
			if (got.mantissa !== want.mantissa)
				flag("mantissa", int'(want.mantissa), int'(got.mantissa));
			if (got.exponent !== want.exponent)
				flag("exponent", int'(want.exponent), int'(got.exponent));
			if (got.target !== want.target)
				flag("target", int'(want.target), int'(got.target));
			if (got.status !== want.status)
				flag("status", int'(want.status), int'(got.status));
			if (got.last !== want.last)
				flag("last", int'(want.last), int'(got.last));
		end
	endtask

	function automatic int idle_len(input logic calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic push_char(input logic [7:0] c, input logic fin);
		gwp_pkg::req_t item;
		item.ch = c;
		item.line_end = fin;
		chars_pending.push_back(item);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], i == s.len() - 1);
	endtask

	task automatic flush_line();
		for (int i = 0; i < line_text.size(); i++)
			push_char(line_text[i], i == line_text.size() - 1);
		line_text.delete();
	endtask

	task automatic add_word();
		string      fav;
		string      num;
		logic [7:0] ltr;
		int         r;
		int         nd;
		int         pt;
		int         vals[4];
		fav = "GGGFIJKRVWXYZAB";
		vals = '{254, 255, 256, 1000};
		if ($urandom_range(0, 99) < 60)
			ltr = fav[$urandom_range(0, fav.len() - 1)];
		else
			ltr = 8'(gwp_pkg::CH_A + $urandom_range(0, 25));
		line_text.push_back(ltr);
		r = $urandom_range(0, 99);
		if (r < 20)
			line_text.push_back(gwp_pkg::CH_MINUS);
		else if (r < 35)
			line_text.push_back(gwp_pkg::CH_PLUS);
		if ((ltr == "V" || ltr == "W") && $urandom_range(0, 2) == 0) begin
			num = $sformatf("%0d", vals[$urandom_range(0, 3)]);
			for (int i = 0; i < num.len(); i++)
				line_text.push_back(num[i]);
			if ($urandom_range(0, 1) == 1) begin
				line_text.push_back(gwp_pkg::CH_DOT);
				line_text.push_back($urandom_range(0, 1) ? "5" : "0");
			end
		end else begin
			r = $urandom_range(0, 99);
			nd = (r < 5) ? 0 : (r < 80) ? $urandom_range(1, 4) : $urandom_range(5, 12);
			pt = ($urandom_range(0, 2) == 0) ? $urandom_range(0, nd) : -1;
			for (int i = 0; i < nd; i++) begin
				if (i == pt)
					line_text.push_back(gwp_pkg::CH_DOT);
				line_text.push_back(8'(gwp_pkg::CH_0 + $urandom_range(0, 9)));
			end
			if (pt == nd)
				line_text.push_back(gwp_pkg::CH_DOT);
		end
	endtask

	task automatic add_corruption();
		int r;
		r = $urandom_range(0, 4);
		case (r)
			0: line_text.push_back(8'($urandom_range(0, 255)));
			1: line_text.push_back(8'("a" + $urandom_range(0, 25)));
			2: line_text.push_back(gwp_pkg::CH_MINUS);
			3: line_text.push_back(gwp_pkg::CH_DOT);
			default: line_text.push_back(" ");
		endcase
	endtask

	task automatic make_line();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			repeat ($urandom_range(1, 5)) add_word();
		end else if (r < 85) begin
			repeat ($urandom_range(0, 3)) add_word();
			add_corruption();
			repeat ($urandom_range(0, 2)) add_word();
		end else begin
			repeat ($urandom_range(1, 6)) line_text.push_back(8'($urandom_range(0, 255)));
		end
		flush_line();
	endtask

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("gcode_word_parser_test: done, errors");
			$finish;
		end
	end

	int   send_gap = 0;
	logic tx_calm = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_gap <= 0;
		end else begin
			if (req_valid && req_ready) begin
				parse_char(req);
				accepted_chars <= accepted_chars + 1;
			end
			if (!(req_valid && !req_ready)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					req_valid <= 1'b0;
				end else if (chars_pending.size() != 0) begin
					req <= chars_pending.pop_front();
					req_valid <= 1'b1;
					send_gap <= idle_len(tx_calm);
					if ($urandom_range(0, 49) == 0)
						tx_calm <= !tx_calm;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	int   stall = 0;
	int   hold_left = 0;
	logic held = 1'b0;
	logic rx_calm = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall <= 0;
			hold_left <= 0;
		end else begin
			if (rsp_valid && rsp_ready)
				check_word(rsp);
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp_ready <= 1'b0;
			end else if (!held && accepted_chars >= 60) begin
				// hold off long enough for the result queue to back up into the input
				hold_left <= 300;
				held <= 1'b1;
				rsp_ready <= 1'b0;
			end else if (stall > 0) begin
				stall <= stall - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				stall <= idle_len(rx_calm);
				if ($urandom_range(0, 49) == 0)
					rx_calm <= !rx_calm;
			end
		end
	end

	initial begin
		push_char(8'h00, 1'b0);
		push_char(8'hFF, 1'b1);
		push_text("G-2Y");
		push_text("V256,");
		push_text("F+-1");
		push_text("X123456789");
		push_text("a");
		push_text("G3");
		while (chars_pending.size() < 430)
			make_line();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (chars_pending.size() != 0 || req_valid || words_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (words_due.size() != 0) begin
			$display("%0t: %0d words expected, none seen", $time, words_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("gcode_word_parser_test: done, clean");
		else
			$display("gcode_word_parser_test: done, errors");
		$finish;
	end

endmodule
